FILE: hw/rtl/nfc_pkg.sv
// ----------------------------------------------------------------------------
// nfc_pkg: shared definitions of the nibble-check frame transmitter
// Opcodes, frame constants, result record and the header check function.
// ----------------------------------------------------------------------------
package nfc_pkg;

  localparam int unsigned RingDepthDefault = 16;

  localparam logic OpEnqueue = 1'b0;
  localparam logic OpSend    = 1'b1;

  localparam logic [7:0] SyncByte   = 8'h55;
  localparam logic [3:0] NibbleMask = 4'hF;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       dropped;
  } res_t;

  // Check nibble: all-ones minus the sum of id and both data nibbles, mod 16.
  function automatic logic [3:0] frame_check(logic [3:0] id, logic [7:0] data);
    logic [3:0] sum;
    sum = id + data[3:0] + data[7:4];
    return NibbleMask - sum;
  endfunction

endpackage

FILE: hw/rtl/nfc_ring_mem.sv
// ----------------------------------------------------------------------------
// nfc_ring_mem: single-port byte ring storage
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module nfc_ring_mem #(
  parameter int unsigned Depth = nfc_pkg::RingDepthDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/nibble_check_frame_transmitter_core.sv
// ----------------------------------------------------------------------------
// nibble_check_frame_transmitter_core: framing transmitter over a byte ring
//
// Input channel (in_valid_i/in_ready_o) carries one command per beat. An
// enqueue (opcode 0) builds a frame of sync 0x55, header {check, id} and the
// data byte and writes it into the ring, or flags dropped when fewer than
// three entries are free. A send (opcode 1) pops one byte when line_ready_i
// is set and the ring holds data. The ring keeps one entry unused, so it
// holds at most RING_DEPTH-1 bytes.
// Output channel (out_valid_o/out_ready_i) returns exactly one result beat
// per command, with the fill level after the command (modulo 16).
// An enqueue writes the frame one byte per state on the single memory port
// (StIdle, StHdr, StDat); a send that pops reads in StIdle, takes data in StRd;
// a drop or empty send goes to StResp. One command is in work at a time; a new
// command is taken while the previous result waits in the output register.
// A stalled receiver holds the finished command in a pending state until the
// output register frees up, and no new command is taken meanwhile.
// Reset empties the ring by clearing both pointers; no clearing pass.
// ----------------------------------------------------------------------------
module nibble_check_frame_transmitter_core #(
  parameter int unsigned RING_DEPTH = nfc_pkg::RingDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [3:0] msg_id_i,
  input  logic [7:0] msg_data_i,
  input  logic       line_ready_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       dropped_o,
  output logic [3:0] fill_level_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StHdr  = 5'b00010,
    StDat  = 5'b00100,
    StRd   = 5'b01000,
    StResp = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [3:0]      id_q, id_d;
  logic [7:0]      data_q, data_d;
  nfc_pkg::res_t   res_q, res_d, fin_res;

  logic            out_valid_q;
  nfc_pkg::res_t   out_res_q;
  logic [3:0]      fill_q;

  logic            mem_we, mem_re;
  logic [PtrW-1:0] mem_addr;
  logic [7:0]      mem_wdata, mem_rdata;

  logic            finish, slot_free, out_load;
  logic [PtrW:0]   fill_cur, fill_next;
  logic [PtrW+4:0] fill_ext;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW:0] ring_fill(logic [PtrW-1:0] w, logic [PtrW-1:0] r);
    logic [PtrW:0] we, re;
    we = {1'b0, w};
    re = {1'b0, r};
    return (we >= re) ? (we - re) : (we + (PtrW+1)'(RING_DEPTH) - re);
  endfunction

  nfc_ring_mem #(
    .Depth (RING_DEPTH),
    .AddrW (PtrW)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign fill_cur  = ring_fill(wptr_q, rptr_q);
  assign slot_free = !out_valid_q || out_ready_i;

  // One command at a time, so ring reads and writes never touch the same
  // entry in overlapping cycles.
  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    id_d      = id_q;
    data_d    = data_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wptr_q;
    mem_wdata = nfc_pkg::SyncByte;
    finish    = 1'b0;
    fin_res   = res_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          id_d   = msg_id_i;
          data_d = msg_data_i;
          res_d  = '0;
          if (opcode_i == nfc_pkg::OpEnqueue) begin
            if (fill_cur >= (PtrW+1)'(RING_DEPTH - 3)) begin
              res_d.dropped = 1'b1;
              state_d       = StResp;
            end else begin
              mem_we  = 1'b1;
              wptr_d  = ptr_next(wptr_q);
              state_d = StHdr;
            end
          end else if (line_ready_i && (rptr_q != wptr_q)) begin
            mem_re   = 1'b1;
            mem_addr = rptr_q;
            state_d  = StRd;
          end else begin
            state_d = StResp;
          end
        end
      end
      StHdr: begin
        mem_we    = 1'b1;
        mem_wdata = {nfc_pkg::frame_check(id_q, data_q), id_q};
        wptr_d    = ptr_next(wptr_q);
        state_d   = StDat;
      end
      StDat: begin
        mem_we    = 1'b1;
        mem_wdata = data_q;
        wptr_d    = ptr_next(wptr_q);
        finish    = 1'b1;
      end
      StRd: begin
        rptr_d           = ptr_next(rptr_q);
        fin_res.tx_valid = 1'b1;
        fin_res.tx_byte  = mem_rdata;
        fin_res.dropped  = 1'b0;
        finish           = 1'b1;
      end
      StResp: begin
        finish = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // Pointers are already advanced; park the result if the output is busy.
    if (finish) begin
      res_d   = fin_res;
      state_d = slot_free ? StIdle : StResp;
    end
  end

  assign out_load  = finish && slot_free;
  assign fill_next = ring_fill(wptr_d, rptr_d);
  assign fill_ext  = {4'b0, fill_next};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wptr_q      <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    data_q <= data_d;
    res_q  <= res_d;
    if (out_load) begin
      out_res_q <= fin_res;
      fill_q    <= fill_ext[3:0];
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign tx_valid_o   = out_res_q.tx_valid;
  assign tx_byte_o    = out_res_q.tx_byte;
  assign dropped_o    = out_res_q.dropped;
  assign fill_level_o = fill_q;

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StIdle || state_q == StHdr || state_q == StDat))
    else $error("ring write outside of a frame write");

  a_read_follows_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |-> ($past(state_q) == StIdle && $past(mem_re)))
    else $error("read data consumed without a preceding ring read");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cur <= (PtrW+1)'(RING_DEPTH - 1))
    else $error("ring fill exceeds capacity");

  a_result_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(fin_res.tx_valid && fin_res.dropped))
    else $error("result both transmits and drops");

endmodule
